// ===== rtl/core/cltp_pkg.sv =====
// shared types and constants for the command line token parser
// used by cltp_parse, cltp_out and command_line_token_parser; no dependencies
package cltp_pkg;

    // default width of the argument accumulator
    localparam int ARG_WIDTH_DEF = 32;

    // width of a reported argument on the result channel
    localparam int ARG_OUT_W = 32;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_B     = 8'h42;

    // result codes: commands, then errors
    typedef enum logic [3:0] {
        CODE_H    = 4'd0,
        CODE_Q    = 4'd1,
        CODE_U    = 4'd2,
        CODE_A    = 4'd3,
        CODE_P    = 4'd4,
        CODE_C    = 4'd5,
        CODE_S    = 4'd6,
        CODE_B    = 4'd7,
        CODE_BAD  = 4'd8,
        CODE_NEG  = 4'd9,
        CODE_BIG  = 4'd10,
        CODE_MANY = 4'd11,
        CODE_FEW  = 4'd12
    } code_t;

    // where the line stands
    typedef enum logic [2:0] {
        PH_LEAD      = 3'd0,
        PH_AFTER_HQ  = 3'd1,
        PH_AFTER_CMD = 3'd2,
        PH_SEP       = 3'd3,
        PH_NUM       = 3'd4,
        PH_ERROR     = 3'd5
    } phase_t;

    // one result of a line
    typedef struct packed {
        logic [ARG_OUT_W-1:0] arg_n;
        logic [ARG_OUT_W-1:0] arg_m;
        code_t                code;
    } res_t;

endpackage

// ===== rtl/core/cltp_parse.sv =====
// per-character parser: phase state machine, argument accumulator, line result
// depends on cltp_pkg
module cltp_parse #(
    parameter int ARG_WIDTH = cltp_pkg::ARG_WIDTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            ch_valid,
    input  logic [7:0]      ch,
    output logic            res_valid,
    output cltp_pkg::res_t  res
);
    import cltp_pkg::*;

    phase_t               phase_reg, phase_next;
    code_t                code_reg, code_next;
    logic [ARG_WIDTH-1:0] acc_reg, acc_next;
    logic [ARG_WIDTH-1:0] first_reg, first_next;
    logic [1:0]           count_reg, count_next;

    logic                 is_eol, is_blank, is_digit;
    logic [1:0]           needed;
    logic [ARG_WIDTH+3:0] acc_times10;
    logic                 acc_over;
    logic [1:0]           eol_count;
    logic [ARG_WIDTH-1:0] eol_first;
    logic                 eol_many;
    logic [ARG_WIDTH+ARG_OUT_W-1:0] ext_m, ext_n;

    // character classes
    assign is_eol   = (ch == CH_NUL) || (ch == CH_LF);
    assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB);
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign needed   = ((code_reg == CODE_P) || (code_reg == CODE_B)) ? 2'd1 : 2'd2;

    // shift-add times ten plus digit, overflow in the top bits
    assign acc_times10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                       + {{ARG_WIDTH{1'b0}}, ch[3:0]};
    assign acc_over    = |acc_times10[ARG_WIDTH+3:ARG_WIDTH];

    // argument commit at line end while a number is open
    always_comb begin
        eol_many  = 1'b0;
        eol_count = count_reg;
        eol_first = first_reg;
        if (phase_reg == PH_NUM) begin
            if (count_reg >= needed) begin
                eol_many = 1'b1;
            end else begin
                eol_count = count_reg + 2'd1;
                if (count_reg == 2'd0) begin
                    eol_first = acc_reg;
                end
            end
        end
    end

    // line result
    always_comb begin
        res.code  = CODE_BAD;
        res.arg_m = '0;
        res.arg_n = '0;
        ext_m     = {{ARG_OUT_W{1'b0}}, eol_first};
        ext_n     = {{ARG_OUT_W{1'b0}}, acc_reg};
        if (eol_many) begin
            res.code = CODE_MANY;
        end else if ((phase_reg == PH_ERROR) || (phase_reg == PH_AFTER_HQ)) begin
            res.code = code_reg;
        end else if ((phase_reg == PH_SEP) || (phase_reg == PH_NUM)) begin
            if (eol_count < needed) begin
                res.code = CODE_FEW;
            end else begin
                res.code  = code_reg;
                res.arg_n = ext_n[ARG_OUT_W-1:0];
                if (needed == 2'd2) begin
                    res.arg_m = ext_m[ARG_OUT_W-1:0];
                end
            end
        end
    end

    assign res_valid = ch_valid && is_eol;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
            code_reg  <= CODE_H;
            acc_reg   <= '0;
            first_reg <= '0;
            count_reg <= '0;
        end else if (ch_valid) begin
            phase_reg <= phase_next;
            code_reg  <= code_next;
            acc_reg   <= acc_next;
            first_reg <= first_next;
            count_reg <= count_next;
        end
    end

    // next state per character
    always_comb begin
        phase_next = phase_reg;
        code_next  = code_reg;
        acc_next   = acc_reg;
        first_next = first_reg;
        count_next = count_reg;
        if (is_eol) begin
            phase_next = PH_LEAD;
            code_next  = CODE_H;
            acc_next   = '0;
            first_next = '0;
            count_next = '0;
        end else begin
            unique case (phase_reg)
                PH_LEAD: begin
                    if (!is_blank) begin
                        phase_next = PH_AFTER_CMD;
                        case (ch)
                            CH_H: begin
                                code_next  = CODE_H;
                                phase_next = PH_AFTER_HQ;
                            end
                            CH_Q: begin
                                code_next  = CODE_Q;
                                phase_next = PH_AFTER_HQ;
                            end
                            CH_U: code_next = CODE_U;
                            CH_A: code_next = CODE_A;
                            CH_P: code_next = CODE_P;
                            CH_C: code_next = CODE_C;
                            CH_S: code_next = CODE_S;
                            CH_B: code_next = CODE_B;
                            default: begin
                                code_next  = CODE_BAD;
                                phase_next = PH_ERROR;
                            end
                        endcase
                    end
                end
                PH_AFTER_HQ: begin
                    if (!is_blank) begin
                        code_next  = CODE_BAD;
                        phase_next = PH_ERROR;
                    end
                end
                PH_AFTER_CMD: begin
                    if (is_blank) begin
                        phase_next = PH_SEP;
                    end else begin
                        code_next  = CODE_BAD;
                        phase_next = PH_ERROR;
                    end
                end
                PH_SEP: begin
                    if (is_digit) begin
                        acc_next   = {{(ARG_WIDTH-4){1'b0}}, ch[3:0]};
                        phase_next = PH_NUM;
                    end else if (ch == CH_MINUS) begin
                        code_next  = CODE_NEG;
                        phase_next = PH_ERROR;
                    end else if (!is_blank) begin
                        code_next  = CODE_BAD;
                        phase_next = PH_ERROR;
                    end
                end
                PH_NUM: begin
                    if (is_digit) begin
                        if (acc_over) begin
                            code_next  = CODE_BIG;
                            phase_next = PH_ERROR;
                        end else begin
                            acc_next = acc_times10[ARG_WIDTH-1:0];
                        end
                    end else if (is_blank) begin
                        if (count_reg >= needed) begin
                            code_next  = CODE_MANY;
                            phase_next = PH_ERROR;
                        end else begin
                            if (count_reg == 2'd0) begin
                                first_next = acc_reg;
                            end
                            count_next = count_reg + 2'd1;
                            phase_next = PH_SEP;
                        end
                    end else begin
                        code_next  = CODE_BAD;
                        phase_next = PH_ERROR;
                    end
                end
                PH_ERROR: begin
                    phase_next = PH_ERROR;
                end
                default: begin
                    phase_next = PH_ERROR;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/cltp_out.sv =====
// result register with a skid stage towards the result channel
// depends on cltp_pkg
module cltp_out (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  cltp_pkg::res_t  in_data,
    output logic            in_ready,
    output logic            out_valid,
    output cltp_pkg::res_t  out_data,
    input  logic            out_ready
);
    import cltp_pkg::*;

    logic main_valid_reg, skid_valid_reg;
    res_t main_reg, skid_reg;
    logic push, space;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign space     = !main_valid_reg || out_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (space) begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= skid_valid_reg && push;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (space) begin
            if (skid_valid_reg) begin
                main_reg <= skid_reg;
                if (push) begin
                    skid_reg <= in_data;
                end
            end else if (push) begin
                main_reg <= in_data;
            end
        end else if (push) begin
            skid_reg <= in_data;
        end
    end

endmodule

// ===== rtl/core/command_line_token_parser.sv =====
// top level of the command line token parser: character stream in, one result per line out
// depends on cltp_pkg, cltp_parse and cltp_out
//
//  channel | direction | tdata fields (lowest bit up)             | item
//  s_      | in        | ch[7:0]                                  | one character
//  m_      | out       | code[3:0] arg_m[35:4] arg_n[67:36] pad   | one line result
//
// one character per cycle while s_tready is high; a line end's result is registered
// the phase state machine and accumulator update once per accepted character
// reset is synchronous on aresetn and starts a fresh line
// a two-entry result stage lets characters flow while a result waits;
// s_tready drops only while both result entries are full
module command_line_token_parser #(
    parameter int ARG_WIDTH = cltp_pkg::ARG_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // code[3:0], arg_m[35:4], arg_n[67:36], zero[71:68]
);
    import cltp_pkg::*;

    logic s_accept, res_valid;
    res_t res, out_res;

    assign s_accept = s_tvalid && s_tready;

    // per-character parser
    cltp_parse #(
        .ARG_WIDTH (ARG_WIDTH)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ch_valid  (s_accept),
        .ch        (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register and skid
    cltp_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    // result transaction packing
    assign m_tdata = {4'b0, out_res.arg_n, out_res.arg_m, out_res.code};

endmodule
